### rtl/core/coss_pkg.sv
// ----------------------------------------------------------------------------
// coss_pkg
// Shared types and constants for the center-out spiral scan core.
// ----------------------------------------------------------------------------
package coss_pkg;

  // grid limits and field widths
  localparam int DIM_W   = 7;            // dimension register width
  localparam int IDX_W   = 6;            // emitted row/column index width
  localparam int POS_W   = 9;            // signed walker coordinate width
  localparam int LEN_W   = 7;            // leg length / leg position width
  localparam int LAYER_W = 6;            // completed layer count width
  localparam int CFG_IDX_W = 1;          // configuration register index width

  localparam logic [DIM_W-1:0] MAX_DIM = 7'd64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

  // leg directions
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  // walk states
  localparam logic [1:0] WS_IDLE = 2'd0;
  localparam logic [1:0] WS_WALK = 2'd1;
  localparam logic [1:0] WS_DONE = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic accept;     // latch a new request
    logic commit;     // apply this cycle's walk update
    logic load_out;   // load the result into the output register
  } coss_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic done_step;  // this cycle's update produces the result
  } coss_sts_t;

endpackage

### rtl/core/coss_ctrl.sv
// ----------------------------------------------------------------------------
// coss_ctrl
// Request sequencer: accepts a request, steps the walker one position per
// cycle to a result (held for a free output), runs the output handshake.
// ----------------------------------------------------------------------------
module coss_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  coss_pkg::coss_sts_t sts,
  output coss_pkg::coss_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  // output slot is free when empty or being drained this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // commands to the datapath
  always_comb begin
    cmd.accept   = in_tvalid && in_tready;
    cmd.commit   = (state_r == S_BUSY) && (!sts.done_step || out_free);
    cmd.load_out = (state_r == S_BUSY) && sts.done_step && out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept) state_nxt = S_BUSY;
      end
      S_BUSY: begin
        if (cmd.load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result loaded over a pending result");

  // an accepted request is worked on in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == S_BUSY))
    else $error("accepted request not processed");

endmodule

### rtl/core/coss_dp.sv
// ----------------------------------------------------------------------------
// coss_dp
// Walker datapath: dimension registers, spiral position and leg counters,
// one walk step per commit, grid test and output payload register.
// ----------------------------------------------------------------------------
module coss_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  input  logic [coss_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [coss_pkg::DIM_W-1:0]            cfg_data,
  input  logic                                  req_restart,
  input  coss_pkg::coss_cmd_t                   cmd,
  output coss_pkg::coss_sts_t                   sts,
  output logic [coss_pkg::IDX_W-1:0]            out_row,
  output logic [coss_pkg::IDX_W-1:0]            out_col,
  output logic                                  out_vres
);

  // configuration registers
  logic [coss_pkg::DIM_W-1:0] row_cnt_r, col_cnt_r;

  // walker state
  logic signed [coss_pkg::POS_W-1:0] cur_row_r, cur_row_nxt;
  logic signed [coss_pkg::POS_W-1:0] cur_col_r, cur_col_nxt;
  logic [1:0]                        leg_dir_r, leg_dir_nxt;
  logic [coss_pkg::LEN_W-1:0]        leg_pos_r, leg_pos_nxt;
  logic [coss_pkg::LEN_W-1:0]        leg_len_r, leg_len_nxt;
  logic [coss_pkg::LAYER_W-1:0]      layer_r, layer_nxt;
  logic [1:0]                        ws_r, ws_nxt;
  logic                              restart_r;

  // output payload
  logic [coss_pkg::IDX_W-1:0] res_row_r, res_col_r;
  logic                       res_vld_r;

  // step evaluation
  logic [coss_pkg::DIM_W-1:0]        rows_eff, cols_eff, dim_max;
  logic [coss_pkg::LAYER_W-1:0]      limit;
  logic [coss_pkg::IDX_W-1:0]        ctr_row, ctr_col;
  logic                              is_start, lim_hit, in_grid, leg_end;
  logic signed [coss_pkg::POS_W-1:0] step_row, step_col;
  logic [coss_pkg::LEN_W-1:0]        step_pos;
  logic [coss_pkg::IDX_W-1:0]        res_row, res_col;
  logic                              res_vld;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= coss_pkg::DIM_W'(1);
      col_cnt_r <= coss_pkg::DIM_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        coss_pkg::REG_ROW_COUNT: row_cnt_r <= cfg_data;
        coss_pkg::REG_COL_COUNT: col_cnt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp dimensions into 1..MAX_DIM
  always_comb begin
    rows_eff = row_cnt_r;
    if (row_cnt_r == '0) rows_eff = coss_pkg::DIM_W'(1);
    else if (row_cnt_r > coss_pkg::MAX_DIM) rows_eff = coss_pkg::MAX_DIM;
    cols_eff = col_cnt_r;
    if (col_cnt_r == '0) cols_eff = coss_pkg::DIM_W'(1);
    else if (col_cnt_r > coss_pkg::MAX_DIM) cols_eff = coss_pkg::MAX_DIM;
  end

  // layer limit and centre cell
  logic [coss_pkg::DIM_W:0]   dim_inc;
  logic [coss_pkg::DIM_W-1:0] rows_dec, cols_dec;
  assign dim_max  = (rows_eff > cols_eff) ? rows_eff : cols_eff;
  assign dim_inc  = {1'b0, dim_max} + (coss_pkg::DIM_W+1)'(1);
  assign limit    = dim_inc[coss_pkg::LAYER_W:1];
  assign rows_dec = rows_eff - coss_pkg::DIM_W'(1);
  assign cols_dec = cols_eff - coss_pkg::DIM_W'(1);
  assign ctr_row  = rows_dec[coss_pkg::IDX_W:1];
  assign ctr_col  = cols_dec[coss_pkg::IDX_W:1];

  assign is_start = restart_r || (ws_r == coss_pkg::WS_IDLE);
  assign lim_hit  = (layer_r >= limit);

  // one position along the current leg
  always_comb begin
    step_row = cur_row_r;
    step_col = cur_col_r;
    case (leg_dir_r)
      coss_pkg::DIR_RIGHT: step_col = cur_col_r + coss_pkg::POS_W'(1);
      coss_pkg::DIR_DOWN:  step_row = cur_row_r + coss_pkg::POS_W'(1);
      coss_pkg::DIR_LEFT:  step_col = cur_col_r - coss_pkg::POS_W'(1);
      default:             step_row = cur_row_r - coss_pkg::POS_W'(1);
    endcase
  end

  assign step_pos = leg_pos_r + coss_pkg::LEN_W'(1);
  assign leg_end  = (step_pos >= leg_len_r);

  // grid test on the stepped position
  assign in_grid = !step_row[coss_pkg::POS_W-1] && !step_col[coss_pkg::POS_W-1]
                && (step_row[coss_pkg::POS_W-2:0] < {1'b0, rows_eff})
                && (step_col[coss_pkg::POS_W-2:0] < {1'b0, cols_eff});

  assign sts.done_step = is_start || (ws_r == coss_pkg::WS_DONE) || lim_hit || in_grid;

  // result selection
  always_comb begin
    res_row = '0;
    res_col = '0;
    res_vld = 1'b0;
    if (is_start) begin
      res_row = ctr_row;
      res_col = ctr_col;
      res_vld = 1'b1;
    end else if ((ws_r == coss_pkg::WS_WALK) && !lim_hit && in_grid) begin
      res_row = step_row[coss_pkg::IDX_W-1:0];
      res_col = step_col[coss_pkg::IDX_W-1:0];
      res_vld = 1'b1;
    end
  end

  // walker update
  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    leg_dir_nxt = leg_dir_r;
    leg_pos_nxt = leg_pos_r;
    leg_len_nxt = leg_len_r;
    layer_nxt   = layer_r;
    ws_nxt      = ws_r;
    if (cmd.commit) begin
      if (is_start) begin
        cur_row_nxt = coss_pkg::POS_W'(ctr_row);
        cur_col_nxt = coss_pkg::POS_W'(ctr_col);
        leg_dir_nxt = coss_pkg::DIR_RIGHT;
        leg_pos_nxt = '0;
        leg_len_nxt = coss_pkg::LEN_W'(1);
        layer_nxt   = '0;
        ws_nxt      = coss_pkg::WS_WALK;
      end else if (ws_r == coss_pkg::WS_WALK) begin
        if (lim_hit) begin
          ws_nxt = coss_pkg::WS_DONE;
        end else begin
          cur_row_nxt = step_row;
          cur_col_nxt = step_col;
          leg_pos_nxt = step_pos;
          if (leg_end) begin
            leg_pos_nxt = '0;
            leg_dir_nxt = leg_dir_r + 2'd1;
            if (leg_dir_r[0]) leg_len_nxt = leg_len_r + coss_pkg::LEN_W'(1);
            if (leg_dir_r == coss_pkg::DIR_UP) layer_nxt = layer_r + coss_pkg::LAYER_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
      cur_col_r <= '0;
      leg_dir_r <= coss_pkg::DIR_RIGHT;
      leg_pos_r <= '0;
      leg_len_r <= coss_pkg::LEN_W'(1);
      layer_r   <= '0;
      ws_r      <= coss_pkg::WS_IDLE;
    end else begin
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      leg_dir_r <= leg_dir_nxt;
      leg_pos_r <= leg_pos_nxt;
      leg_len_r <= leg_len_nxt;
      layer_r   <= layer_nxt;
      ws_r      <= ws_nxt;
    end
  end

  // request latch and output payload
  always_ff @(posedge clk) begin
    if (cmd.accept) restart_r <= req_restart;
    if (cmd.load_out) begin
      res_row_r <= res_row;
      res_col_r <= res_col;
      res_vld_r <= res_vld;
    end
  end

  assign out_row  = res_row_r;
  assign out_col  = res_col_r;
  assign out_vres = res_vld_r;

  // walk state never takes the unused code
  a_ws_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (ws_r == coss_pkg::WS_IDLE) || (ws_r == coss_pkg::WS_WALK) || (ws_r == coss_pkg::WS_DONE))
    else $error("walk state corrupted");

  // position within the leg stays below the leg length
  a_pos_in_leg: assert property (@(posedge clk) disable iff (!rst_n)
    leg_pos_r < leg_len_r)
    else $error("leg position past leg length");

  // leg length follows the layer: 2k+1 for right/down, 2k+2 for left/up
  a_len_layer: assert property (@(posedge clk) disable iff (!rst_n)
    leg_len_r == ({layer_r, 1'b1} + coss_pkg::LEN_W'(leg_dir_r[1])))
    else $error("leg length out of step with layer count");

endmodule

### rtl/core/center_out_spiral_scan_core.sv
// After a request is accepted, the walker steps over off-grid positions until
// it reaches a grid cell or the layer limit, then the result is registered.
// A new request is taken only after the last result is loaded; the walker
// takes one spiral position per cycle, its result held for a free output.
// Reset: synchronous active-low; dimensions return to 1x1, the walk to not
// started, and the output register to empty.
// ----------------------------------------------------------------------------
// center_out_spiral_scan_core
// Center-out square spiral address generator over a rows x cols grid.
// ----------------------------------------------------------------------------
module center_out_spiral_scan_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // request stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [0] restart, [7:1] zero
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [15:0]                         out_tdata,  // [5:0] row_index,
                                                          // [11:6] col_index,
                                                          // [12] valid_res, [15:13] zero
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [coss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [coss_pkg::DIM_W-1:0]          cfg_data
);

  coss_pkg::coss_cmd_t cmd;
  coss_pkg::coss_sts_t sts;

  logic [coss_pkg::IDX_W-1:0] out_row, out_col;
  logic                       out_vres;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  // request sequencing
  coss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // walker and payload
  coss_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_restart (in_tdata[0]),
    .cmd         (cmd),
    .sts         (sts),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_vres    (out_vres)
  );

  // pack the result
  assign out_tdata = {3'b000, out_vres, out_col, out_row};

endmodule
